// ----- hdl/mvm_pkg.sv -----
// Shared constants, types and helpers of the matrix-vector multiply unit.
package mvm_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 65536;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 64;
    localparam int ROW_INDEX_W = 16;
    localparam int NUM_ROWS_W  = 17;
    localparam int NUM_COLS_W  = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = CFG_INDEX_W'(1);

    // request function codes on s_func
    localparam logic FUNC_LOAD_X = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic load_we;   // write vector element, advance load pointer
        logic mac_rd;    // capture matrix element, read x at current column
        logic mul_en;    // register the product
        logic acc_en;    // accumulate, advance column, emit at row end
    } mvm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic row_end;   // current column is the last of the row
        logic out_busy;  // result register full and not drained this cycle
    } mvm_status_t;

    // Column count minus one, clamped to [1, MAX_COLS]
    function automatic logic [COL_W-1:0] eff_cols_m1(input logic [NUM_COLS_W-1:0] v);
        logic [31:0] n;
        n = 32'(v);
        if (n == 32'd0) begin
            n = 32'd1;
        end else if (n > 32'(MAX_COLS)) begin
            n = 32'(MAX_COLS);
        end
        return COL_W'(n - 32'd1);
    endfunction

    // Row count minus one, clamped to [1, MAX_ROWS]
    function automatic logic [ROW_W-1:0] eff_rows_m1(input logic [NUM_ROWS_W-1:0] v);
        logic [31:0] n;
        n = 32'(v);
        if (n == 32'd0) begin
            n = 32'd1;
        end else if (n > 32'(MAX_ROWS)) begin
            n = 32'(MAX_ROWS);
        end
        return ROW_W'(n - 32'd1);
    endfunction

endpackage

// ----- hdl/mvm_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/mvm_ctrl.sv -----
// Sequencing state machine: request accept, multiply and accumulate steps.
module mvm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_func,
    output logic                s_ready,
    output mvm_pkg::mvm_cmd_t   cmd,
    input  mvm_pkg::mvm_status_t status
);
    import mvm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_MATRIX) begin
                        cmd.mac_rd = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold while a finished row still waits in the result register
                if (!(status.row_end && status.out_busy)) begin
                    cmd.acc_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_mul_then_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_ACC))
        else $error("multiply step not followed by accumulate");

    a_no_emit_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_en && status.row_end) |-> !status.out_busy)
        else $error("row result issued into a full result register");

    a_matrix_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == FUNC_MATRIX)) |=> (state_reg == ST_MUL))
        else $error("matrix request did not start a multiply");

endmodule

// ----- hdl/mvm_datapath.sv -----
// Vector store, counters, multiplier, saturating accumulator and result register.
module mvm_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [mvm_pkg::VALUE_W-1:0]    s_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mvm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mvm_pkg::ROW_INDEX_W-1:0]       m_row_index,
    output logic signed [mvm_pkg::ACC_W-1:0]      m_y_value,
    output logic                                  m_last,
    output logic                                  m_overflow,
    input  mvm_pkg::mvm_cmd_t                     cmd,
    output mvm_pkg::mvm_status_t                  status
);
    import mvm_pkg::*;

    // configuration, kept as clamped size minus one
    logic [COL_W-1:0] cols_m1_reg;
    logic [ROW_W-1:0] rows_m1_reg;
    logic             cfg_wr;
    logic             cfg_hit;

    // progress counters
    logic [COL_W-1:0] load_cnt_reg;
    logic [COL_W-1:0] col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    // arithmetic
    logic signed [VALUE_W-1:0] a_reg;
    logic signed [VALUE_W-1:0] x_rdata;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   sum;
    logic                      sat_reg;
    logic                      sat_next;
    logic                      ovf;
    logic                      emit;
    logic                      final_row;

    // result register
    logic                          m_valid_reg;
    logic [ROW_INDEX_W-1:0]        m_row_index_reg;
    logic signed [ACC_W-1:0]       m_y_value_reg;
    logic                          m_last_reg;
    logic                          m_overflow_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

    mvm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (cmd.load_we),
        .waddr (load_cnt_reg),
        .wdata (s_value),
        .re    (cmd.mac_rd),
        .raddr (col_cnt_reg),
        .rdata (x_rdata)
    );

    // saturating Q32.32 add
    always_comb begin
        sum      = acc_reg + prod_reg;
        ovf      = (acc_reg[ACC_W-1] == prod_reg[ACC_W-1]) &&
                   (sum[ACC_W-1] != acc_reg[ACC_W-1]);
        acc_next = ovf ? (acc_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
        sat_next = sat_reg || ovf;
    end

    assign status.row_end  = (col_cnt_reg == cols_m1_reg);
    assign status.out_busy = m_valid_reg && !m_ready;
    assign emit            = cmd.acc_en && status.row_end;
    assign final_row       = (row_cnt_reg == rows_m1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_m1_reg  <= '0;
            rows_m1_reg  <= '0;
            load_cnt_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
        end else if (cfg_hit) begin
            if (cfg_index == REG_NUM_ROWS) begin
                rows_m1_reg <= eff_rows_m1(NUM_ROWS_W'(cfg_data));
            end else begin
                cols_m1_reg <= eff_cols_m1(NUM_COLS_W'(cfg_data));
            end
            load_cnt_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
        end else begin
            if (cmd.load_we) begin
                load_cnt_reg <= (load_cnt_reg == cols_m1_reg) ? '0
                                                              : load_cnt_reg + COL_W'(1);
            end
            if (cmd.acc_en) begin
                if (status.row_end) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= final_row ? '0 : row_cnt_reg + ROW_W'(1);
                    acc_reg     <= '0;
                    sat_reg     <= 1'b0;
                end else begin
                    col_cnt_reg <= col_cnt_reg + COL_W'(1);
                    acc_reg     <= acc_next;
                    sat_reg     <= sat_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_rd) begin
            a_reg <= s_value;
        end
        if (cmd.mul_en) begin
            prod_reg <= a_reg * x_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_row_index_reg <= ROW_INDEX_W'(row_cnt_reg);
            m_y_value_reg   <= acc_next;
            m_last_reg      <= final_row;
            m_overflow_reg  <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_index = m_row_index_reg;
    assign m_y_value   = m_y_value_reg;
    assign m_last      = m_last_reg;
    assign m_overflow  = m_overflow_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_cnt_reg <= cols_m1_reg) && (load_cnt_reg <= cols_m1_reg))
        else $error("column or load pointer beyond row length");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= rows_m1_reg)
        else $error("row counter beyond row count");

    a_emit_restarts_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !cfg_hit) |=> (col_cnt_reg == '0) && (acc_reg == '0) && m_valid_reg)
        else $error("row end did not restart the accumulation");

endmodule

// ----- hdl/matrix_vector_multiply_unit.sv -----
// Top level of the streaming matrix-vector multiply unit (y = A*x, Q16.16 in, Q32.32 out).
//
// The unit computes y = A*x in fixed point. A request with s_func = 0 loads the next
// element of x into a local vector RAM (1024 x 32 bits); the load pointer wraps after
// num_cols loads. A request with s_func = 1 is the next matrix element in row order:
// it is multiplied by the stored x element of its column and added into a 64-bit
// Q32.32 accumulator that saturates on overflow. After the last column of a row one
// result leaves on the m_ channel with the row index, the dot product, a flag on the
// final row (after which the row count starts over with the same vector) and an
// overflow flag if the row sum saturated. A vector load is written in the accept step;
// a matrix element steps through accept plus RAM read, 32x32 multiply into a product
// register and saturating add, and no new request is taken until its add is done.
// The result sits in an output register, so the next row proceeds while it waits;
// only the element that ends a further row holds in the add step until the register
// drains. Configuration writes (index 0 = num_rows, 1 = num_cols, clamped to 1..65536
// and 1..1024) are taken every cycle, should only come while the unit is idle, and
// restart the row, column and load counters; the vector RAM keeps its data and has no
// reset, so each x entry must be loaded before a matrix element uses it.
module matrix_vector_multiply_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic signed [mvm_pkg::VALUE_W-1:0]    s_value,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mvm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // row results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mvm_pkg::ROW_INDEX_W-1:0]       m_row_index,
    output logic signed [mvm_pkg::ACC_W-1:0]      m_y_value,
    output logic                                  m_last,
    output logic                                  m_overflow
);
    import mvm_pkg::*;

    mvm_cmd_t    cmd;
    mvm_status_t status;

    mvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    mvm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_y_value   (m_y_value),
        .m_last      (m_last),
        .m_overflow  (m_overflow),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- tb/tb_matrix_vector_multiply_unit.sv -----
// Self-checking testbench of the matrix-vector multiply unit: directed corners plus random rows.
module tb_matrix_vector_multiply_unit;
    import mvm_pkg::*;

    // an index past the register list; writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = '1;

    localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

    localparam int DRAIN_CYCLES = 8;     // pipeline is three deep, leave margin
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all

    typedef struct {
        logic [ROW_INDEX_W-1:0] row_index;
        logic signed [ACC_W-1:0] y_value;
        logic last;
        logic overflow;
    } row_result_t;

    // Tracks x, the row/column/load pointers and the running dot product,
    // and queues the row results the unit must produce.
    class gemv_tracker;
        logic signed [VALUE_W-1:0] x_store [MAX_COLS];
        bit x_written [MAX_COLS];
        int unsigned load_ptr, col_ptr, row_ptr;
        longint acc;
        bit sat;
        logic [NUM_ROWS_W-1:0] rows_reg;
        logic [NUM_COLS_W-1:0] cols_reg;
        row_result_t pending_rows[$];
        int errors;

        function new();
            rows_reg = 1;
            cols_reg = 1;
            errors = 0;
            clear_progress();
        endfunction

        function void clear_progress();
            load_ptr = 0;
            col_ptr = 0;
            row_ptr = 0;
            acc = 0;
            sat = 0;
        endfunction

        function int unsigned active_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned active_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        // true when the next matrix element would read a loaded x entry
        function bit column_loaded();
            int unsigned c;
            c = (col_ptr >= active_cols()) ? 0 : col_ptr;
            return x_written[c];
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_NUM_ROWS) begin
                rows_reg = data[NUM_ROWS_W-1:0];
                clear_progress();
            end else if (idx == REG_NUM_COLS) begin
                cols_reg = data[NUM_COLS_W-1:0];
                clear_progress();
            end
        endfunction

        function void take_request(logic func, logic signed [VALUE_W-1:0] value);
            int unsigned cols, rows_n, slot, r;
            longint product, sum;
            bit last_row;
            cols = active_cols();
            if (func == FUNC_LOAD_X) begin
                slot = (load_ptr >= cols) ? 0 : load_ptr;
                x_store[slot] = value;
                x_written[slot] = 1'b1;
                load_ptr = (slot + 1 >= cols) ? 0 : slot + 1;
                return;
            end
            slot = (col_ptr >= cols) ? 0 : col_ptr;
            product = longint'(value) * longint'(x_store[slot]);
            sum = acc + product;
            // same-sign operands with a flipped sum sign: clamp and latch the flag
            if (acc[63] == product[63] && sum[63] != acc[63]) begin
                sum = acc[63] ? ACC_MIN : ACC_MAX;
                sat = 1'b1;
            end
            acc = sum;
            if (slot + 1 < cols) begin
                col_ptr = slot + 1;
                return;
            end
            rows_n = active_rows();
            r = (row_ptr >= rows_n) ? 0 : row_ptr;
            last_row = (r + 1 >= rows_n);
            pending_rows.push_back('{row_index: 16'(r), y_value: acc,
                                     last: last_row, overflow: sat});
            col_ptr = 0;
            acc = 0;
            sat = 1'b0;
            row_ptr = last_row ? 0 : r + 1;
        endfunction

        function void check_row(logic [ROW_INDEX_W-1:0] row_index,
                                logic signed [ACC_W-1:0] y_value,
                                logic last, logic overflow);
            row_result_t want;
            if (pending_rows.size() == 0) begin
                $error("unexpected row result: row_index %0d y_value %0d", row_index, y_value);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            if (row_index !== want.row_index) begin
                $error("row_index: expected %0d, actual %0d", want.row_index, row_index);
                errors++;
            end
            if (y_value !== want.y_value) begin
                $error("y_value: expected %0d, actual %0d", want.y_value, y_value);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = FUNC_LOAD_X;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ROW_INDEX_W-1:0] m_row_index;
    logic signed [ACC_W-1:0] m_y_value;
    logic m_last;
    logic m_overflow;

    gemv_tracker gemv = new();

    // idling odds in percent, changed per phase
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    matrix_vector_multiply_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_row_index(m_row_index),
        .m_y_value  (m_y_value),
        .m_last     (m_last),
        .m_overflow (m_overflow)
    );

    always #5 aclk = ~aclk;

    // Result side: check what is taken at this edge, then pick ready for the next one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                gemv.check_row(m_row_index, m_y_value, m_last, m_overflow);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mix of extremes, full-range words and small Q16.16 values around zero.
    function automatic logic signed [VALUE_W-1:0] element_value();
        int small_val;
        small_val = $urandom_range(0, 262143);
        case ($urandom_range(7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2, 3, 4: return $urandom;
            default: return small_val - 131072;
        endcase
    endfunction

    // One request; the tracker sees it at the edge it is taken.
    task automatic send_request(input logic func, input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        gemv.take_request(func, value);
    endtask

    // x load with load_pct percent odds, else a matrix element; never reads an unloaded x entry.
    task automatic send_stream_item(input int load_pct);
        logic func;
        func = ($urandom_range(99) < load_pct) ? FUNC_LOAD_X : FUNC_MATRIX;
        if (func == FUNC_MATRIX && !gemv.column_loaded()) begin
            func = FUNC_LOAD_X;
        end
        send_request(func, element_value());
    endtask

    task automatic send_vector();
        int unsigned i;
        for (i = 0; i < gemv.active_cols(); i++) begin
            send_request(FUNC_LOAD_X, element_value());
        end
    endtask

    // Sender holds off until every row result is in and the pipeline has emptied.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (gemv.pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        gemv.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int ph, phase_items, n, k;
        int unsigned row_cap;
        bit first;
        logic [CFG_DATA_W-1:0] cols_w, rows_w;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed corners ----
        // 3 columns, 2 rows; x built so row 0 saturates high and row 1 saturates low
        write_register(REG_NUM_COLS, CFG_DATA_W'(3));
        write_register(REG_NUM_ROWS, CFG_DATA_W'(2));
        send_request(FUNC_LOAD_X, Q_MIN);
        send_request(FUNC_LOAD_X, Q_MIN);
        send_request(FUNC_LOAD_X, Q_MAX);
        send_request(FUNC_MATRIX, Q_MIN);   // +2^62
        send_request(FUNC_MATRIX, Q_MIN);   // +2^62 -> clamps to max
        send_request(FUNC_MATRIX, '0);      // flag stays set
        send_request(FUNC_MATRIX, Q_MAX);
        send_request(FUNC_MATRIX, Q_MAX);
        send_request(FUNC_MATRIX, Q_MIN);   // pushes below min, final row
        // row counter wrapped back to 0 with the same vector
        send_request(FUNC_MATRIX, Q_ONE);
        send_request(FUNC_MATRIX, '1);
        send_request(FUNC_MATRIX, '0);
        // a partial row, then a write to a nonexistent register must not disturb it
        send_request(FUNC_MATRIX, Q_MAX);
        wait_until_idle();
        write_register(REG_UNUSED, '1);
        send_request(FUNC_MATRIX, Q_ONE);
        send_request(FUNC_MATRIX, -Q_ONE);
        // zero in both registers behaves as one
        wait_until_idle();
        write_register(REG_NUM_COLS, '0);
        write_register(REG_NUM_ROWS, '0);
        send_request(FUNC_LOAD_X, Q_MAX);
        send_request(FUNC_MATRIX, Q_MAX);
        send_request(FUNC_MATRIX, Q_MIN);

        // ---- largest sizes: exact maxima then clamped ones, a partial row each ----
        wait_until_idle();
        write_register(REG_NUM_COLS, CFG_DATA_W'(MAX_COLS));
        write_register(REG_NUM_ROWS, CFG_DATA_W'(MAX_ROWS));
        for (k = 0; k < 48; k++) send_stream_item(50);
        wait_until_idle();
        write_register(REG_NUM_COLS, '1);   // above the column limit
        write_register(REG_NUM_ROWS, '1);   // above the row limit
        for (k = 0; k < 48; k++) send_stream_item(50);

        // ---- random rows under four idling regimes ----
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            phase_items = 0;
            first = 1'b1;
            while (phase_items < 120) begin
                wait_until_idle();
                case ($urandom_range(9))
                    0:       cols_w = '0;
                    1:       cols_w = CFG_DATA_W'($urandom_range(9, 16));
                    default: cols_w = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                case ($urandom_range(9))
                    0:       rows_w = '0;
                    1:       rows_w = CFG_DATA_W'($urandom_range(MAX_ROWS, 131071));
                    default: rows_w = CFG_DATA_W'($urandom_range(1, 5));
                endcase
                if ($urandom_range(1)) begin
                    write_register(REG_NUM_COLS, cols_w);
                    write_register(REG_NUM_ROWS, rows_w);
                end else begin
                    write_register(REG_NUM_ROWS, rows_w);
                    write_register(REG_NUM_COLS, cols_w);
                end
                if ($urandom_range(4) == 0) begin
                    write_register(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
                end
                send_vector();
                phase_items += gemv.active_cols();
                // whole rows, a product or two, and sometimes a row left unfinished
                row_cap = (gemv.active_rows() > 4) ? 4 : gemv.active_rows();
                n = row_cap * gemv.active_cols() * $urandom_range(1, 2)
                    + $urandom_range(0, gemv.active_cols() - 1);
                for (k = 0; k < n; k++) begin
                    if (first && k == n / 2) wait_until_idle();
                    send_stream_item(12);
                end
                phase_items += n;
                first = 1'b0;
            end
        end

        // ---- drain and report ----
        wait_until_idle();
        repeat (20) @(posedge aclk);
        if (gemv.errors == 0 && gemv.pending_rows.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
